// ----- src/bmp24_stream_to_rgb565_top_defines.svh -----
// Assertion macros used by the checker file of the BMP to RGB565 stream block.
`ifndef BMP24_STREAM_TO_RGB565_TOP_DEFINES_SVH
`define BMP24_STREAM_TO_RGB565_TOP_DEFINES_SVH

// Check a property while out of reset.
`define BMP565_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BMP565_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/bmp565_pkg.sv -----
// Types and constants of the BMP to RGB565 stream block.
`default_nettype none

package bmp565_pkg;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_DONE
   } phase_type;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_X      = 2'd2;
   localparam logic [1:0] CSR_ORIGIN_Y      = 2'd3;

   localparam int SCREEN_W = 13;
   localparam int ORIGIN_X_W = 8;
   localparam int ORIGIN_Y_W = 12;
   localparam int COORD_W = 12;
   localparam int COLOR_W = 16;
   localparam int RSP_DATA_W = 2 * COORD_W + COLOR_W;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd240;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd320;

   localparam logic [31:0] POS_SIGNATURE   = 32'd1;
   localparam logic [31:0] POS_OFFSET      = 32'd13;
   localparam logic [31:0] POS_WIDTH       = 32'd21;
   localparam logic [31:0] POS_HEIGHT      = 32'd25;
   localparam logic [31:0] POS_PLANES      = 32'd27;
   localparam logic [31:0] POS_DEPTH       = 32'd29;
   localparam logic [31:0] POS_COMPRESSION = 32'd33;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [15:0] BMP_PLANES    = 16'd1;
   localparam logic [15:0] BMP_DEPTH     = 16'd24;
   localparam logic [31:0] MIN_OFFSET    = 32'd34;

endpackage

`default_nettype wire

// ----- src/bmp24_stream_to_rgb565_top.sv -----
// Top level of the BMP to RGB565 stream block: header parse, pixel walk and result register.
//
// Usage:
//   req channel: one BMP file byte per transfer in file order (req_tdata); req_tuser
//   high marks the first byte of a file and restarts the parse.
//   rsp channel: one result per transfer; rsp_tuser gives the kind (pixel, header
//   accepted, header rejected), rsp_tdata the screen column, row and RGB565 colour
//   (all zero for header results).
//   csr port: write screen size and image origin while the block is idle.
// Timing:
//   Each byte is handled in the cycle it is accepted; its result, if any, is in the
//   output register in the next cycle. One byte per cycle is sustained unless a held
//   result stalls; the pixel walk uses running counters, so no byte ever waits on another.
// Reset:
//   Synchronous; clears the output valid, restarts the parse at header byte 0
//   and loads screen 240 x 320 with the origin at 0, 0.
// Stall:
//   While rsp_tready is low with a result held, req_tready drops and the held
//   result stays; a taken result frees the register in the same cycle.
`default_nettype none

module bmp24_stream_to_rgb565_top #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,   // data_byte
   input  wire logic [0:0]                           req_tuser,   // start_of_file
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [bmp565_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // pixel_x, pixel_y, color
   output logic [1:0]                                rsp_tuser,   // kind
   input  wire logic                                 csr_we,
   input  wire logic [1:0]                           csr_index,
   input  wire logic [bmp565_pkg::SCREEN_W-1:0]      csr_wdata
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int ROW_W = $clog2(3 * MAX_DIM + 4);
   localparam int CMP_W = (DIM_W > bmp565_pkg::SCREEN_W) ? DIM_W : bmp565_pkg::SCREEN_W;
   localparam int ADD_W = CMP_W + 1;
   localparam int SW = bmp565_pkg::SCREEN_W;

   logic [SW-1:0]                       screen_width_ff;
   logic [SW-1:0]                       screen_height_ff;
   logic [bmp565_pkg::ORIGIN_X_W-1:0]   origin_x_ff;
   logic [bmp565_pkg::ORIGIN_Y_W-1:0]   origin_y_ff;

   bmp565_pkg::phase_type phase_ff, phase_in;
   logic [31:0]       byte_position_ff, byte_position_in;
   logic [31:0]       header_shift_ff, header_shift_in;
   logic              header_valid_ff, header_valid_in;
   logic              bottom_up_ff, bottom_up_in;
   logic [31:0]       data_offset_ff, data_offset_in;
   logic [DIM_W-1:0]  image_width_ff, image_width_in;
   logic [DIM_W-1:0]  image_height_ff, image_height_in;
   logic [ROW_W-1:0]  data_len_ff, data_len_in;
   logic [ROW_W-1:0]  row_size_ff, row_size_in;
   logic [SW-1:0]     crop_width_ff, crop_width_in;
   logic [SW-1:0]     crop_height_ff, crop_height_in;
   logic [ROW_W-1:0]  byte_in_row_ff, byte_in_row_in;
   logic [1:0]        triple_ff, triple_in;
   logic [DIM_W-1:0]  column_ff, column_in;
   logic [DIM_W-1:0]  row_in_file_ff, row_in_file_in;
   logic [7:0]        blue_ff, blue_in;
   logic [7:0]        green_ff, green_in;

   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [bmp565_pkg::RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                          rsp_tuser_ff, rsp_tuser_in;

   logic              fire;
   logic              emit;
   logic [1:0]        emit_kind;
   logic [bmp565_pkg::RSP_DATA_W-1:0] emit_data;

   bmp565_pkg::phase_type cur_phase;
   logic [31:0]       cur_position;
   logic [31:0]       cur_shift;
   logic              cur_valid;
   logic              cur_bottom_up;
   logic [31:0]       shifted;
   logic [31:0]       position_next;
   logic [31:0]       height_mag;
   logic              final_valid;
   logic [SW-1:0]     avail_width;
   logic [SW-1:0]     avail_height;
   logic [ROW_W-1:0]  triple_len;
   logic [ROW_W-1:0]  bir_next;
   logic [DIM_W-1:0]  disp_row;
   logic [ADD_W-1:0]  x_sum;
   logic [ADD_W-1:0]  y_sum;
   logic [15:0]       pixel_color;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= bmp565_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= bmp565_pkg::SCREEN_HEIGHT_RST;
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bmp565_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            bmp565_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            bmp565_pkg::CSR_ORIGIN_X:      origin_x_ff <= csr_wdata[bmp565_pkg::ORIGIN_X_W-1:0];
            bmp565_pkg::CSR_ORIGIN_Y:      origin_y_ff <= csr_wdata[bmp565_pkg::ORIGIN_Y_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= bmp565_pkg::PH_HEADER;
         byte_position_ff <= '0;
         header_shift_ff  <= '0;
         header_valid_ff  <= 1'b1;
         bottom_up_ff     <= 1'b1;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         byte_position_ff <= byte_position_in;
         header_shift_ff  <= header_shift_in;
         header_valid_ff  <= header_valid_in;
         bottom_up_ff     <= bottom_up_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_offset_ff  <= data_offset_in;
      image_width_ff  <= image_width_in;
      image_height_ff <= image_height_in;
      data_len_ff     <= data_len_in;
      row_size_ff     <= row_size_in;
      crop_width_ff   <= crop_width_in;
      crop_height_ff  <= crop_height_in;
      byte_in_row_ff  <= byte_in_row_in;
      triple_ff       <= triple_in;
      column_ff       <= column_in;
      row_in_file_ff  <= row_in_file_in;
      blue_ff         <= blue_in;
      green_ff        <= green_in;
      rsp_tdata_ff    <= rsp_tdata_in;
      rsp_tuser_ff    <= rsp_tuser_in;
   end

   always_comb begin
      cur_phase     = req_tuser[0] ? bmp565_pkg::PH_HEADER : phase_ff;
      cur_position  = req_tuser[0] ? '0 : byte_position_ff;
      cur_shift     = req_tuser[0] ? '0 : header_shift_ff;
      cur_valid     = req_tuser[0] ? 1'b1 : header_valid_ff;
      cur_bottom_up = req_tuser[0] ? 1'b1 : bottom_up_ff;

      shifted       = {req_tdata, cur_shift[31:8]};
      position_next = cur_position + 32'd1;
      height_mag    = shifted[31] ? (~shifted + 32'd1) : shifted;
      avail_width   = screen_width_ff - SW'(origin_x_ff);
      avail_height  = screen_height_ff - SW'(origin_y_ff);
      final_valid   = cur_valid && (shifted == '0)
                      && (SW'(origin_x_ff) < screen_width_ff)
                      && (SW'(origin_y_ff) < screen_height_ff);
      triple_len    = ROW_W'({image_width_ff, 1'b0}) + ROW_W'(image_width_ff);
      bir_next      = byte_in_row_ff + ROW_W'(1);
      disp_row      = bottom_up_ff ? (image_height_ff - DIM_W'(1) - row_in_file_ff)
                                   : row_in_file_ff;
      x_sum         = ADD_W'(origin_x_ff) + ADD_W'(column_ff);
      y_sum         = ADD_W'(origin_y_ff) + ADD_W'(disp_row);
      pixel_color   = {req_tdata[7:3], green_ff[7:2], blue_ff[7:3]};

      phase_in         = phase_ff;
      byte_position_in = byte_position_ff;
      header_shift_in  = header_shift_ff;
      header_valid_in  = header_valid_ff;
      bottom_up_in     = bottom_up_ff;
      data_offset_in   = data_offset_ff;
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      data_len_in      = data_len_ff;
      row_size_in      = row_size_ff;
      crop_width_in    = crop_width_ff;
      crop_height_in   = crop_height_ff;
      byte_in_row_in   = byte_in_row_ff;
      triple_in        = triple_ff;
      column_in        = column_ff;
      row_in_file_in   = row_in_file_ff;
      blue_in          = blue_ff;
      green_in         = green_ff;
      emit             = 1'b0;
      emit_kind        = bmp565_pkg::KIND_PIXEL;
      emit_data        = '0;

      if (fire) begin
         phase_in         = cur_phase;
         byte_position_in = cur_position;
         header_shift_in  = cur_shift;
         header_valid_in  = cur_valid;
         bottom_up_in     = cur_bottom_up;
         unique case (cur_phase)
            bmp565_pkg::PH_HEADER: begin
               header_shift_in  = shifted;
               byte_position_in = position_next;
               byte_in_row_in   = '0;
               triple_in        = '0;
               column_in        = '0;
               row_in_file_in   = '0;
               if (cur_position == bmp565_pkg::POS_SIGNATURE) begin
                  if (shifted[31:16] != bmp565_pkg::BMP_SIGNATURE) header_valid_in = 1'b0;
               end
               if (cur_position == bmp565_pkg::POS_OFFSET) begin
                  data_offset_in = shifted;
                  if (shifted < bmp565_pkg::MIN_OFFSET) header_valid_in = 1'b0;
               end
               if (cur_position == bmp565_pkg::POS_WIDTH) begin
                  image_width_in = DIM_W'(shifted);
                  if (shifted > 32'(MAX_DIM)) header_valid_in = 1'b0;
               end
               if (cur_position == bmp565_pkg::POS_HEIGHT) begin
                  bottom_up_in    = !shifted[31];
                  image_height_in = DIM_W'(height_mag);
                  if (height_mag > 32'(MAX_DIM)) header_valid_in = 1'b0;
               end
               if (cur_position == bmp565_pkg::POS_PLANES) begin
                  if (shifted[31:16] != bmp565_pkg::BMP_PLANES) header_valid_in = 1'b0;
               end
               if (cur_position == bmp565_pkg::POS_DEPTH) begin
                  if (shifted[31:16] != bmp565_pkg::BMP_DEPTH) header_valid_in = 1'b0;
               end
               if (cur_position == bmp565_pkg::POS_COMPRESSION) begin
                  emit            = 1'b1;
                  header_valid_in = final_valid;
                  data_len_in     = triple_len;
                  row_size_in     = (triple_len + ROW_W'(3)) & ~ROW_W'(3);
                  crop_width_in   = (CMP_W'(image_width_ff) < CMP_W'(avail_width))
                                    ? SW'(image_width_ff) : avail_width;
                  crop_height_in  = (CMP_W'(image_height_ff) < CMP_W'(avail_height))
                                    ? SW'(image_height_ff) : avail_height;
                  if (!final_valid) begin
                     emit_kind = bmp565_pkg::KIND_REJECT;
                     phase_in  = bmp565_pkg::PH_DONE;
                  end else begin
                     emit_kind = bmp565_pkg::KIND_ACCEPT;
                     if (image_width_ff == '0 || image_height_ff == '0) begin
                        phase_in = bmp565_pkg::PH_DONE;
                     end else if (position_next >= data_offset_ff) begin
                        phase_in = bmp565_pkg::PH_PIXEL;
                     end else begin
                        phase_in = bmp565_pkg::PH_SKIP;
                     end
                  end
               end
            end
            bmp565_pkg::PH_SKIP: begin
               byte_position_in = position_next;
               if (position_next >= data_offset_ff) phase_in = bmp565_pkg::PH_PIXEL;
            end
            bmp565_pkg::PH_PIXEL: begin
               byte_in_row_in = bir_next;
               if (byte_in_row_ff < data_len_ff) begin
                  case (triple_ff)
                     2'd0: begin
                        blue_in   = req_tdata;
                        green_in  = '0;
                        triple_in = 2'd1;
                     end
                     2'd1: begin
                        green_in  = req_tdata;
                        triple_in = 2'd2;
                     end
                     default: begin
                        triple_in = 2'd0;
                        column_in = column_ff + DIM_W'(1);
                        if (CMP_W'(column_ff) < CMP_W'(crop_width_ff)
                            && CMP_W'(disp_row) < CMP_W'(crop_height_ff)) begin
                           emit      = 1'b1;
                           emit_kind = bmp565_pkg::KIND_PIXEL;
                           emit_data = {pixel_color, y_sum[bmp565_pkg::COORD_W-1:0],
                                        x_sum[bmp565_pkg::COORD_W-1:0]};
                        end
                     end
                  endcase
               end
               if (bir_next == row_size_ff) begin
                  byte_in_row_in = '0;
                  triple_in      = '0;
                  column_in      = '0;
                  row_in_file_in = row_in_file_ff + DIM_W'(1);
                  if (row_in_file_ff + DIM_W'(1) == image_height_ff) begin
                     phase_in = bmp565_pkg::PH_DONE;
                  end
               end
            end
            bmp565_pkg::PH_DONE: begin
               phase_in = bmp565_pkg::PH_DONE;
            end
         endcase
      end

      rsp_tvalid_in = fire ? emit : (rsp_tvalid_ff && !rsp_tready);
      rsp_tdata_in  = (fire && emit) ? emit_data : rsp_tdata_ff;
      rsp_tuser_in  = (fire && emit) ? emit_kind : rsp_tuser_ff;
   end

endmodule

`default_nettype wire

// ----- src/bmp565_chk.sv -----
// Port checker of the BMP to RGB565 stream block and its bind to the top level.
`default_nettype none
`include "bmp24_stream_to_rgb565_top_defines.svh"

module bmp565_chk (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [bmp565_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [1:0]                         rsp_tuser
);

   `BMP565_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")
   `BMP565_ASSERT(a_empty_ready, !rsp_tvalid |-> req_tready, "input stalled with empty output")
   `BMP565_ASSERT(a_header_zero, rsp_tvalid && rsp_tuser != bmp565_pkg::KIND_PIXEL |-> rsp_tdata == '0, "header result with data")
   `BMP565_ASSERT(a_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind bmp24_stream_to_rgb565_top bmp565_chk u_bmp565_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
